### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on one clock with an asynchronous active-low reset.
`define KPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/kpc_pkg.sv
// Package with the constants, register codes and types of the key press classifier.
package kpc_pkg;

	localparam int KPC_FIELD_W    = 3;
	localparam int KPC_NUM_KEYS   = 3;
	localparam int KPC_CNT_W      = 16;
	localparam int KPC_CLICK_W    = 8;
	localparam int KPC_CFG_IDX_W  = 8;
	localparam int KPC_CFG_DATA_W = 16;

	localparam logic [KPC_CNT_W-1:0]   KPC_GAP_MAX   = 16'hffff;
	localparam logic [KPC_CNT_W-1:0]   KPC_HOLD_MAX  = 16'hffff;
	localparam logic [KPC_CLICK_W-1:0] KPC_CLICK_MAX = 8'hff;

	localparam logic [KPC_CNT_W-1:0]   KPC_RST_CLICK_GAP  = 16'd10;
	localparam logic [KPC_CNT_W-1:0]   KPC_RST_LONG_PRESS = 16'd40;
	localparam logic [KPC_CLICK_W-1:0] KPC_RST_MULTI      = 8'd2;
	localparam logic [KPC_FIELD_W-1:0] KPC_RST_ACTIVE_LOW = 3'd0;

	typedef enum logic [KPC_CFG_IDX_W-1:0] {
		REG_CLICK_GAP   = 8'd0,
		REG_LONG_PRESS  = 8'd1,
		REG_MULTI_CLICK = 8'd2,
		REG_ACTIVE_LOW  = 8'd3
	} kpc_reg_t;

	// Thresholds that every lane compares against.
	typedef struct packed {
		logic [KPC_CNT_W-1:0]   click_gap;
		logic [KPC_CNT_W-1:0]   long_press;
		logic [KPC_CLICK_W-1:0] multi_count;
	} kpc_cfg_t;

	// What one lane found for its key on this tick.
	typedef struct packed {
		logic held;
		logic edge_seen;
		logic shrt;
		logic lng;
		logic multi;
	} kpc_flags_t;

	typedef struct packed {
		logic [KPC_FIELD_W-1:0] held_now;
		logic [KPC_FIELD_W-1:0] press_edge;
		logic [KPC_FIELD_W-1:0] short_press;
		logic [KPC_FIELD_W-1:0] long_press;
		logic [KPC_FIELD_W-1:0] multi_click;
	} kpc_item_t;

endpackage

### rtl/core/kpc_intf.sv
// Handshake channel interfaces of the key press classifier.
interface kpc_in_if import kpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KPC_FIELD_W-1:0] raw_pressed;

	modport source (output valid, output raw_pressed, input ready);
	modport sink (input valid, input raw_pressed, output ready);
endinterface

interface kpc_out_if import kpc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [KPC_FIELD_W-1:0] held_now;
	logic [KPC_FIELD_W-1:0] press_edge;
	logic [KPC_FIELD_W-1:0] short_press;
	logic [KPC_FIELD_W-1:0] long_press;
	logic [KPC_FIELD_W-1:0] multi_click;

	modport source (
		output valid, output held_now, output press_edge, output short_press,
		output long_press, output multi_click, input ready
	);
	modport sink (
		input valid, input held_now, input press_edge, input short_press,
		input long_press, input multi_click, output ready
	);
endinterface

interface kpc_cfg_if import kpc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [KPC_CFG_IDX_W-1:0]  index;
	logic [KPC_CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/kpc_lane.sv
// One key's state and its per-tick classification.
module kpc_lane import kpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       level,
	input  kpc_cfg_t   cfg,
	output kpc_flags_t flags
);

	logic                   last_q;
	logic [KPC_CNT_W-1:0]   gap_q;
	logic [KPC_CNT_W-1:0]   hold_q;
	logic [KPC_CLICK_W-1:0] click_q;
	logic                   rel_q;

	logic [KPC_CNT_W-1:0]   gap_d;
	logic [KPC_CNT_W-1:0]   hold_d;
	logic [KPC_CLICK_W-1:0] click_d;
	logic                   rel_d;

	always_comb begin
		gap_d   = gap_q;
		hold_d  = hold_q;
		click_d = click_q;
		rel_d   = rel_q;
		flags   = '0;
		flags.held      = level;
		flags.edge_seen = level & ~last_q;
		if (level && last_q) begin
			if (gap_q == '0) begin
				if (hold_q != KPC_HOLD_MAX)
					hold_d = hold_q + 16'd1;
				// The long press test sees the hold count after this tick's increment.
				if (rel_q && (hold_d > cfg.long_press)) begin
					rel_d     = 1'b0;
					flags.lng = 1'b1;
				end
			end else if (gap_q < cfg.click_gap) begin
				if (click_q != KPC_CLICK_MAX)
					click_d = click_q + 8'd1;
			end
			gap_d = '0;
		end else begin
			if (({1'b0, gap_q} == ({1'b0, cfg.click_gap} + 17'd1)) && (click_q == '0)) begin
				if (!rel_q)
					rel_d = 1'b1;
				else
					flags.shrt = 1'b1;
			end
			if (gap_q > cfg.click_gap)
				click_d = '0;
			if (({1'b0, click_d} + 9'd1) >= {1'b0, cfg.multi_count})
				flags.multi = 1'b1;
			if (gap_q != KPC_GAP_MAX)
				gap_d = gap_q + 16'd1;
			hold_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			gap_q   <= KPC_GAP_MAX;
			hold_q  <= '0;
			click_q <= '0;
			rel_q   <= 1'b1;
		end else if (en) begin
			last_q  <= level;
			gap_q   <= gap_d;
			hold_q  <= hold_d;
			click_q <= click_d;
			rel_q   <= rel_d;
		end
	end

endmodule

### rtl/core/kpc_merge.sv
// Packs the lane flags into one result and holds up to two results for the sink.
module kpc_merge import kpc_pkg::*; #(
	parameter int LANES = KPC_FIELD_W
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  kpc_flags_t lane_flags [LANES],
	input  logic       pop,
	output logic       full,
	output logic       not_empty,
	output kpc_item_t  head
);

	kpc_item_t  item;
	kpc_item_t  e0_q;
	kpc_item_t  e1_q;
	logic [1:0] cnt_q;

	always_comb begin
		item = '0;
		for (int k = 0; k < LANES; k++) begin
			item.held_now[k]    = lane_flags[k].held;
			item.press_edge[k]  = lane_flags[k].edge_seen;
			item.short_press[k] = lane_flags[k].shrt;
			item.long_press[k]  = lane_flags[k].lng;
			item.multi_click[k] = lane_flags[k].multi;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0)
				e0_q <= item;
			else
				e1_q <= item;
		end else if (pop && !push) begin
			e0_q <= e1_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				e0_q <= item;
			end else begin
				e0_q <= e1_q;
				e1_q <= item;
			end
		end
	end

endmodule

### rtl/core/key_press_classifier_unit.sv
// Latency: a result is buffered in the cycle after its scan tick is accepted.
// Throughput: one tick per cycle; all key lanes update in parallel in that cycle.
// A two-entry result buffer lets input continue while one result waits; input
// stalls only when both entries are held. Configuration writes apply to later ticks.
// Reset: thresholds 10/40/2, no inverted keys, per-key state at its idle values.
module key_press_classifier_unit import kpc_pkg::*; #(
	parameter int NUM_KEYS = KPC_NUM_KEYS
) (
	input  logic             clk,
	input  logic             arst_n,
	kpc_in_if.sink           in_ch,
	kpc_out_if.source        out_ch,
	kpc_cfg_if.sink          cfg_ch
);

	// Keys past the field width can never show a result, so they get no lane.
	localparam int LANES = (NUM_KEYS < KPC_FIELD_W) ? NUM_KEYS : KPC_FIELD_W;

	logic [KPC_CNT_W-1:0]   click_gap_q;
	logic [KPC_CNT_W-1:0]   long_press_q;
	logic [KPC_CLICK_W-1:0] multi_count_q;
	logic [KPC_FIELD_W-1:0] active_low_q;

	kpc_cfg_t               lane_cfg;
	kpc_flags_t             lane_flags [LANES];
	logic [KPC_FIELD_W-1:0] level;
	logic                   accept;
	logic                   pop;
	logic                   full;
	logic                   not_empty;
	kpc_item_t              head;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_gap_q   <= KPC_RST_CLICK_GAP;
			long_press_q  <= KPC_RST_LONG_PRESS;
			multi_count_q <= KPC_RST_MULTI;
			active_low_q  <= KPC_RST_ACTIVE_LOW;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_CLICK_GAP:   click_gap_q   <= cfg_ch.data;
				REG_LONG_PRESS:  long_press_q  <= cfg_ch.data;
				REG_MULTI_CLICK: multi_count_q <= cfg_ch.data[KPC_CLICK_W-1:0];
				REG_ACTIVE_LOW:  active_low_q  <= cfg_ch.data[KPC_FIELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign lane_cfg.click_gap   = click_gap_q;
	assign lane_cfg.long_press  = long_press_q;
	assign lane_cfg.multi_count = multi_count_q;

	assign level        = in_ch.raw_pressed ^ active_low_q;
	assign in_ch.ready  = !full;
	assign accept       = in_ch.valid && !full;
	assign pop          = not_empty && out_ch.ready;

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		kpc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.level  (level[k]),
			.cfg    (lane_cfg),
			.flags  (lane_flags[k])
		);
	end

	kpc_merge #(
		.LANES (LANES)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.lane_flags (lane_flags),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	assign out_ch.valid       = not_empty;
	assign out_ch.held_now    = head.held_now;
	assign out_ch.press_edge  = head.press_edge;
	assign out_ch.short_press = head.short_press;
	assign out_ch.long_press  = head.long_press;
	assign out_ch.multi_click = head.multi_click;

endmodule

### rtl/core/kpc_checker.sv
// Port-level assertions for the key press classifier and their bind.
`include "assert_macros.svh"

module kpc_checker (
	input logic       clk,
	input logic       arst_n,
	kpc_in_if.sink    in_ch,
	kpc_out_if.source out_ch,
	kpc_cfg_if.sink   cfg_ch
);

	// A pending result stays offered until the sink takes it.
	`KPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped before it was taken")

	// Input stalls only while buffered results are waiting.
	`KPC_ASSERT(a_stall_has_result, clk, arst_n, in_ch.ready || out_ch.valid, "input stalled with no result pending")

	// An accepted request is always followed in the next cycle by a valid result on the output.
	`KPC_ASSERT_NEXT(a_result_follows, clk, arst_n, in_ch.valid && in_ch.ready, out_ch.valid, "accepted request gave no result")

	// A result never shows a short and a long press for the same key, and a press edge only while that key is held.
	`KPC_ASSERT(a_flag_consistency, clk, arst_n, !out_ch.valid || (((out_ch.short_press & out_ch.long_press) == 3'd0) && ((out_ch.press_edge & ~out_ch.held_now) == 3'd0)), "inconsistent result flags")

	// The configuration port never pushes back.
	`KPC_ASSERT(a_cfg_ready, clk, arst_n, cfg_ch.ready, "configuration port not ready")

endmodule

bind key_press_classifier_unit kpc_checker u_kpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.in_ch  (in_ch),
	.out_ch (out_ch),
	.cfg_ch (cfg_ch)
);
